// ----- rtl/ille_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed linked list engine package
// Shared widths, request and status codes, controller states and the
// command and status types that pass between controller and datapath.
// ----------------------------------------------------------------------------
package ille_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 16;
  localparam int VIN_W  = 32;
  localparam int VOUT_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 11;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - LEN_W - VOUT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET      = 3'd0,
    CMD_ADD_HEAD = 3'd1,
    CMD_ADD_TAIL = 3'd2,
    CMD_ADD_POS  = 3'd3,
    CMD_DEL_POS  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    RS_DONE   = 2'd0,
    RS_ABSENT = 2'd1,
    RS_FULL   = 2'd2
  } res_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ALLOC,
    ST_ALLOC_WAIT,
    ST_INS,
    ST_INS_WALK,
    ST_INS_LINK,
    ST_INS_PREV,
    ST_GET_WALK,
    ST_GET_VAL,
    ST_DEL_WALK,
    ST_DEL_HEAD,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_FIN
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_MISS,
    OP_FULL,
    OP_WALK_POS,
    OP_WALK_POS_M1,
    OP_WALK_STEP,
    OP_GET_VAL,
    OP_ALLOC_POP,
    OP_ALLOC_TAKE,
    OP_ALLOC_FRESH,
    OP_INS_HEAD,
    OP_INS_VAL,
    OP_INS_LINK,
    OP_INS_PREV,
    OP_DEL_HEAD,
    OP_DEL_RD,
    OP_DEL_WR,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             pos_neg;
    logic             pos_zero;
    logic             pos_ge_cnt;
    logic             pos_gt_cnt;
    logic             free_nonempty;
    logic             fresh_avail;
    logic             rem_zero;
    logic             ins_zero;
  } dp_stat_t;

endpackage

// ----- rtl/ille_dpath.sv -----
// ----------------------------------------------------------------------------
// Indexed linked list datapath
// Node value and link memories, free slot stack, list head and counters,
// link walker and result registers, driven one operation per cycle.
// ----------------------------------------------------------------------------
module ille_dpath
  import ille_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_op_t                   op,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [POS_W-1:0]  in_pos,
  input  logic signed [VIN_W-1:0]  in_value,
  output dp_stat_t                 stat,
  output logic signed [VOUT_W-1:0] out_value,
  output logic [STAT_W-1:0]        out_status,
  output logic [LEN_W-1:0]         out_length
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int PW = (SW > 15) ? SW + 1 : 16;
  localparam logic [SW-1:0] NULL_SLOT = SW'(CAPACITY);

  logic [VALUE_BITS-1:0] node_value [CAPACITY];
  logic [SW-1:0]         node_link  [CAPACITY];
  logic [IW-1:0]         free_stack [CAPACITY];

  logic [CMD_W-1:0]      cmd_r;
  logic [POS_W-1:0]      pos_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [SW-1:0]         head_r, head_nxt;
  logic [SW-1:0]         count_r, count_nxt;
  logic [SW-1:0]         free_top_r, free_top_nxt;
  logic [SW-1:0]         fresh_r, fresh_nxt;
  logic [SW-1:0]         cur_r;
  logic                  pend_r;
  logic [SW-1:0]         rem_r;
  logic [IW-1:0]         slot_r;
  logic [IW-1:0]         victim_r;
  logic [VOUT_W-1:0]     res_value_r;
  res_status_t           res_status_r;
  logic [VOUT_W-1:0]     out_value_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [LEN_W-1:0]      out_length_r;

  logic [SW-1:0]         link_rd_r;
  logic [VALUE_BITS-1:0] value_rd_r;
  logic [IW-1:0]         free_rd_r;

  logic [SW-1:0]         cur_now;
  logic [IW-1:0]         link_raddr;
  logic [IW-1:0]         free_raddr;
  logic [PW-1:0]         pos_u;
  logic [PW-1:0]         cnt_u;
  logic                  pos_neg;
  logic [SW-1:0]         ins_at;
  logic [VALUE_BITS-1:0] in_val_fit;
  logic [VOUT_W-1:0]     value_q_out;

  logic                  val_we;
  logic                  link_we;
  logic [IW-1:0]         link_waddr;
  logic [SW-1:0]         link_wdata;
  logic                  free_we;
  logic [IW-1:0]         free_wdata;

  // Stored values are cut or sign extended to the node width, and back.
  if (VALUE_BITS <= VIN_W) begin : g_in_cut
    assign in_val_fit = in_value[VALUE_BITS-1:0];
  end else begin : g_in_ext
    assign in_val_fit = {{(VALUE_BITS - VIN_W){in_value[VIN_W-1]}}, in_value};
  end

  if (VALUE_BITS >= VOUT_W) begin : g_out_cut
    assign value_q_out = value_rd_r[VOUT_W-1:0];
  end else begin : g_out_ext
    assign value_q_out = {{(VOUT_W - VALUE_BITS){value_rd_r[VALUE_BITS-1]}}, value_rd_r};
  end

  // While walking, the freshly read link is the next slot to visit.
  assign cur_now    = pend_r ? link_rd_r : cur_r;
  assign link_raddr = (op == OP_DEL_RD) ? link_rd_r[IW-1:0] : cur_now[IW-1:0];
  assign free_raddr = IW'(free_top_r - 1'b1);

  assign pos_neg = pos_r[POS_W-1];
  assign pos_u   = PW'(pos_r[POS_W-2:0]);
  assign cnt_u   = PW'(count_r);

  always_comb begin
    case (cmd_r)
      CMD_ADD_TAIL: ins_at = count_r;
      CMD_ADD_POS:  ins_at = pos_neg ? '0 : SW'(pos_u);
      default:      ins_at = '0;
    endcase
  end

  assign stat.cmd           = cmd_r;
  assign stat.pos_neg       = pos_neg;
  assign stat.pos_zero      = (pos_r == '0);
  assign stat.pos_ge_cnt    = (pos_u >= cnt_u);
  assign stat.pos_gt_cnt    = (pos_u > cnt_u);
  assign stat.free_nonempty = (free_top_r != '0);
  assign stat.fresh_avail   = (fresh_r < NULL_SLOT);
  assign stat.rem_zero      = (rem_r == '0);
  assign stat.ins_zero      = (ins_at == '0);

  // Memory write control.
  always_comb begin
    val_we     = 1'b0;
    link_we    = 1'b0;
    link_waddr = slot_r;
    link_wdata = head_r;
    free_we    = 1'b0;
    free_wdata = cur_r[IW-1:0];
    unique case (op)
      OP_INS_HEAD: begin
        val_we  = 1'b1;
        link_we = 1'b1;
      end
      OP_INS_VAL: begin
        val_we = 1'b1;
      end
      OP_INS_LINK: begin
        link_we    = 1'b1;
        link_wdata = link_rd_r;
      end
      OP_INS_PREV: begin
        link_we    = 1'b1;
        link_waddr = cur_r[IW-1:0];
        link_wdata = SW'(slot_r);
      end
      OP_DEL_HEAD: begin
        free_we = 1'b1;
      end
      OP_DEL_WR: begin
        link_we    = 1'b1;
        link_waddr = cur_r[IW-1:0];
        link_wdata = link_rd_r;
        free_we    = 1'b1;
        free_wdata = victim_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      node_value[slot_r] <= val_r;
    end
    if (link_we) begin
      node_link[link_waddr] <= link_wdata;
    end
    if (free_we) begin
      free_stack[free_top_r[IW-1:0]] <= free_wdata;
    end
    value_rd_r <= node_value[cur_now[IW-1:0]];
    link_rd_r  <= node_link[link_raddr];
    free_rd_r  <= free_stack[free_raddr];
  end

  // List bookkeeping.
  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    free_top_nxt = free_top_r;
    fresh_nxt    = fresh_r;
    unique case (op)
      OP_ALLOC_POP:   free_top_nxt = free_top_r - 1'b1;
      OP_ALLOC_FRESH: fresh_nxt = fresh_r + 1'b1;
      OP_INS_HEAD: begin
        head_nxt  = SW'(slot_r);
        count_nxt = count_r + 1'b1;
      end
      OP_INS_PREV:    count_nxt = count_r + 1'b1;
      OP_DEL_HEAD: begin
        head_nxt     = link_rd_r;
        free_top_nxt = free_top_r + 1'b1;
        count_nxt    = count_r - 1'b1;
      end
      OP_DEL_WR: begin
        free_top_nxt = free_top_r + 1'b1;
        count_nxt    = count_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= NULL_SLOT;
      count_r    <= '0;
      free_top_r <= '0;
      fresh_r    <= '0;
    end else begin
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      free_top_r <= free_top_nxt;
      fresh_r    <= fresh_nxt;
    end
  end

  // Request, walker and result registers.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        cmd_r        <= in_cmd;
        pos_r        <= in_pos;
        val_r        <= in_val_fit;
        res_value_r  <= '0;
        res_status_r <= RS_DONE;
      end
      OP_MISS: begin
        res_status_r <= RS_ABSENT;
        res_value_r  <= (cmd_r == CMD_GET) ? '1 : '0;
      end
      OP_FULL: res_status_r <= RS_FULL;
      OP_WALK_POS: begin
        rem_r  <= SW'(pos_u);
        cur_r  <= head_r;
        pend_r <= 1'b0;
      end
      OP_WALK_POS_M1: begin
        rem_r  <= SW'(pos_u - 1'b1);
        cur_r  <= head_r;
        pend_r <= 1'b0;
      end
      OP_INS_VAL: begin
        rem_r  <= ins_at - 1'b1;
        cur_r  <= head_r;
        pend_r <= 1'b0;
      end
      OP_WALK_STEP: begin
        cur_r  <= cur_now;
        pend_r <= 1'b1;
        if (rem_r != '0) begin
          rem_r <= rem_r - 1'b1;
        end
      end
      OP_GET_VAL:     res_value_r <= value_q_out;
      OP_ALLOC_TAKE:  slot_r <= free_rd_r;
      OP_ALLOC_FRESH: slot_r <= fresh_r[IW-1:0];
      OP_DEL_RD:      victim_r <= link_rd_r[IW-1:0];
      OP_OUT: begin
        out_value_r  <= res_value_r;
        out_status_r <= res_status_r;
        out_length_r <= LEN_W'(count_r);
      end
      default: begin
      end
    endcase
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_length = out_length_r;

endmodule

// ----- rtl/ille_ctrl.sv -----
// ----------------------------------------------------------------------------
// Indexed linked list controller
// Sequences each request through decode, slot allocation, link walk and
// update steps, and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module ille_ctrl
  import ille_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       pos_miss;

  assign out_free = !out_valid_r || out_tready;
  assign pos_miss = stat.pos_neg || stat.pos_ge_cnt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.cmd)
          CMD_GET:      state_nxt = pos_miss ? ST_FIN : ST_GET_WALK;
          CMD_ADD_HEAD: state_nxt = ST_ALLOC;
          CMD_ADD_TAIL: state_nxt = ST_ALLOC;
          CMD_ADD_POS: begin
            state_nxt = (!stat.pos_neg && stat.pos_gt_cnt) ? ST_FIN : ST_ALLOC;
          end
          CMD_DEL_POS:  state_nxt = pos_miss ? ST_FIN : ST_DEL_WALK;
          default:      state_nxt = ST_FIN;
        endcase
      end
      ST_ALLOC: begin
        priority if (stat.free_nonempty) begin
          state_nxt = ST_ALLOC_WAIT;
        end else if (stat.fresh_avail) begin
          state_nxt = ST_INS;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_ALLOC_WAIT: state_nxt = ST_INS;
      ST_INS:        state_nxt = stat.ins_zero ? ST_FIN : ST_INS_WALK;
      ST_INS_WALK: begin
        if (stat.rem_zero) begin
          state_nxt = ST_INS_LINK;
        end
      end
      ST_INS_LINK:   state_nxt = ST_INS_PREV;
      ST_INS_PREV:   state_nxt = ST_FIN;
      ST_GET_WALK: begin
        if (stat.rem_zero) begin
          state_nxt = ST_GET_VAL;
        end
      end
      ST_GET_VAL:    state_nxt = ST_FIN;
      ST_DEL_WALK: begin
        if (stat.rem_zero) begin
          state_nxt = stat.pos_zero ? ST_DEL_HEAD : ST_DEL_RD;
        end
      end
      ST_DEL_HEAD:   state_nxt = ST_FIN;
      ST_DEL_RD:     state_nxt = ST_DEL_WR;
      ST_DEL_WR:     state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op = OP_LOAD;
        end
      end
      ST_DECODE: begin
        case (stat.cmd)
          CMD_GET:     op = pos_miss ? OP_MISS : OP_WALK_POS;
          CMD_ADD_POS: begin
            if (!stat.pos_neg && stat.pos_gt_cnt) begin
              op = OP_MISS;
            end
          end
          CMD_DEL_POS: begin
            priority if (pos_miss) begin
              op = OP_MISS;
            end else if (stat.pos_zero) begin
              op = OP_WALK_POS;
            end else begin
              op = OP_WALK_POS_M1;
            end
          end
          CMD_ADD_HEAD, CMD_ADD_TAIL: op = OP_NOP;
          default:     op = OP_MISS;
        endcase
      end
      ST_ALLOC: begin
        priority if (stat.free_nonempty) begin
          op = OP_ALLOC_POP;
        end else if (stat.fresh_avail) begin
          op = OP_ALLOC_FRESH;
        end else begin
          op = OP_FULL;
        end
      end
      ST_ALLOC_WAIT: op = OP_ALLOC_TAKE;
      ST_INS:        op = stat.ins_zero ? OP_INS_HEAD : OP_INS_VAL;
      ST_INS_WALK:   op = OP_WALK_STEP;
      ST_INS_LINK:   op = OP_INS_LINK;
      ST_INS_PREV:   op = OP_INS_PREV;
      ST_GET_WALK:   op = OP_WALK_STEP;
      ST_GET_VAL:    op = OP_GET_VAL;
      ST_DEL_WALK:   op = OP_WALK_STEP;
      ST_DEL_HEAD:   op = OP_DEL_HEAD;
      ST_DEL_RD:     op = OP_DEL_RD;
      ST_DEL_WR:     op = OP_DEL_WR;
      ST_FIN: begin
        if (out_free) begin
          op = OP_OUT;
        end
      end
      default:       op = OP_NOP;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_FIN && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ----- rtl/indexed_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// Indexed linked list engine
// Keeps a bounded singly linked list of signed values and serves get,
// insert and delete requests by list position, one result beat per request.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. A get, a delete or an insert past the
// head walks the links from the head, one node memory read per cycle. An
// insert that reuses a freed slot first reads it from the free stack. A miss,
// an unknown command or a dropped insert returns without a walk. The next
// request beat can be taken in the cycle after the result register is loaded;
// the slowest request is an add at the tail of a list of CAPACITY - 1 entries.
// A new request beat is taken while the previous result still waits in the
// output register; a request only stalls at its end while that earlier beat
// has not been taken. Node and free slot memories are not cleared after reset;
// slots freed by deletes are recycled from the free stack first, and fresh
// slots are handed out only while that stack is empty.
module indexed_linked_list_engine
  import ille_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position[15:0], value_in[47:16]
  input  logic [CMD_W-1:0]       in_tuser,   // cmd[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // value_out[31:0], length_now[42:32]
  output logic [STAT_W-1:0]      out_tuser   // status[1:0]
);

  dp_op_t                   dp_op;
  dp_stat_t                 dp_stat;
  logic signed [VOUT_W-1:0] res_value;
  logic [STAT_W-1:0]        res_status;
  logic [LEN_W-1:0]         res_length;

  ille_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (dp_stat),
    .op         (dp_op)
  );

  ille_dpath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (dp_op),
    .in_cmd     (in_tuser),
    .in_pos     (in_tdata[POS_W-1:0]),
    .in_value   (in_tdata[POS_W +: VIN_W]),
    .stat       (dp_stat),
    .out_value  (res_value),
    .out_status (res_status),
    .out_length (res_length)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_length, res_value};
  assign out_tuser = res_status;

  // The result register is only reloaded once the previous beat is gone.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_op == OP_OUT) |-> (!out_tvalid || out_tready))
    else $error("result register reloaded while a beat is pending");

  // A request is latched exactly when an input beat is taken.
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_op == OP_LOAD) |-> (in_tvalid && in_tready))
    else $error("request latched without an input beat");

  // A dropped insert never carries a read value.
  a_full_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == RS_FULL)) |-> (out_tdata[VOUT_W-1:0] == '0))
    else $error("store full result with nonzero value");

endmodule
